// ===== rtl/khte_pkg.sv =====
package khte_pkg;

  // Result status codes.
  localparam logic [2:0] StInserted = 3'd0;
  localparam logic [2:0] StUpdated  = 3'd1;
  localparam logic [2:0] StDeleted  = 3'd2;
  localparam logic [2:0] StDelMiss  = 3'd3;
  localparam logic [2:0] StHit      = 3'd4;
  localparam logic [2:0] StMiss     = 3'd5;
  localparam logic [2:0] StFull     = 3'd6;
  localparam logic [2:0] StTooLong  = 3'd7;

  // Operation codes; the spare code behaves as a search.
  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpDelete = 2'd1;
  localparam logic [1:0] OpSearch = 2'd2;
  localparam logic [1:0] OpSpare  = 2'd3;

  // Configuration register addresses.
  localparam logic [2:0] AddrBucketCount = 3'd0;

  // Largest bucket count that takes effect.
  localparam logic [10:0] MaxBuckets = 11'd1024;

  // Sequencer states.
  typedef enum logic [11:0] {
    S_CLEAR    = 12'b0000_0000_0001,
    S_IDLE     = 12'b0000_0000_0010,
    S_FIN      = 12'b0000_0000_0100,
    S_META_RD  = 12'b0000_0000_1000,
    S_META_CHK = 12'b0000_0001_0000,
    S_KEY_RD   = 12'b0000_0010_0000,
    S_KEY_CHK  = 12'b0000_0100_0000,
    S_OP       = 12'b0000_1000_0000,
    S_COPY_RD  = 12'b0001_0000_0000,
    S_COPY_WR  = 12'b0010_0000_0000,
    S_MOD      = 12'b0100_0000_0000,
    S_DONE     = 12'b1000_0000_0000
  } state_e;

endpackage

// ===== rtl/keyed_hash_table_engine_unit.sv =====
// Keyed hash table with one-at-a-time hashing over a fixed pool of entries.
// Input channel: one key byte per transaction (in_valid_i / in_stall_o) with
// key_last_i on the final byte; operation_i and value_i are taken from the
// final byte. A non-final byte is taken and gives no result.
// The final byte starts the lookup unless the key is too long: for each entry
// the sequencer reads the metadata (META_RD, META_CHK) and, on a hash and
// length match, compares key bytes (KEY_RD, KEY_CHK) from the single-port key
// store. An insert then copies the key (COPY_RD, COPY_WR). The bucket comes
// from a bit-serial remainder unit.
// Output channel: one result per key (out_valid_o / out_stall_i), held in an
// output register; while it waits, the next key's bytes are still taken.
// After reset a clearing pass empties the entry pool; input is stalled
// during it, while configuration writes over APB are taken as ever.
// bucket_count (address 0) must be written only while the block is idle.
module keyed_hash_table_engine_unit #(
  parameter int ENTRIES   = 64,
  parameter int KEY_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  key_byte_i,
  input  logic        key_last_i,
  input  logic [31:0] value_i,
  // Output channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] found_value_o,
  output logic [31:0] hash_value_o,
  output logic [9:0]  bucket_o
);

  localparam int EW  = $clog2(ENTRIES);
  localparam int KBW = $clog2(KEY_BYTES);
  localparam int LW  = $clog2(KEY_BYTES + 1);
  localparam int KAW = $clog2(ENTRIES * KEY_BYTES);
  localparam int MW  = 1 + LW + 32 + 32;
  localparam logic [EW-1:0] LastEntry = EW'(ENTRIES - 1);
  localparam logic [LW-1:0] KeyMax    = LW'(KEY_BYTES);

  // Metadata word: {valid, key length, hash, value}.
  typedef struct packed {
    logic          valid;
    logic [LW-1:0] len;
    logic [31:0]   hash;
    logic [31:0]   value;
  } meta_t;

  khte_pkg::state_e state_q, state_d;

  logic [10:0]    bc_q;
  logic [31:0]    acc_q, acc_d;
  logic [LW-1:0]  len_q, len_d;
  logic           ovl_q, ovl_d;
  logic [1:0]     op_q, op_d;
  logic [31:0]    val_q, val_d;
  logic [31:0]    h_q, h_d;
  logic [EW-1:0]  idx_q, idx_d;
  logic [KBW-1:0] j_q, j_d;
  logic [EW-1:0]  free_q, free_d;
  logic           free_ok_q, free_ok_d;
  logic           hit_q, hit_d;
  meta_t          mword_q, mword_d;
  logic [2:0]     st_q, st_d;
  logic [31:0]    found_q, found_d;
  logic [9:0]     rem_q, rem_d;
  logic [4:0]     divcnt_q, divcnt_d;

  logic        out_valid_q, out_valid_d;
  logic [2:0]  out_st_q, out_st_d;
  logic [31:0] out_found_q, out_found_d;
  logic [31:0] out_hash_q, out_hash_d;
  logic [9:0]  out_bucket_q, out_bucket_d;

  // RAM ports.
  logic [EW-1:0]  meta_addr;
  logic           meta_we;
  meta_t          meta_wdata;
  meta_t          meta_rdata;
  logic [KBW-1:0] kb_addr;
  logic           kb_we;
  logic [7:0]     kb_rdata;
  logic [KAW-1:0] kr_addr;
  logic           kr_we;
  logic [7:0]     kr_rdata;

  logic        in_take;
  logic        cfg_wr;
  logic [31:0] hb, hc, hn;
  logic [31:0] f1, f2, f3;
  logic [10:0] eff;
  logic [10:0] div_t;
  logic [KAW-1:0] entry_base;
  logic           last_key_byte;

  khte_ram #(.WIDTH(MW), .DEPTH(ENTRIES)) u_meta (
    .clk_i   (clk_i),
    .addr_i  (meta_addr),
    .we_i    (meta_we),
    .wdata_i (meta_wdata),
    .rdata_o (meta_rdata)
  );

  khte_ram #(.WIDTH(8), .DEPTH(KEY_BYTES)) u_keybuf (
    .clk_i   (clk_i),
    .addr_i  (kb_addr),
    .we_i    (kb_we),
    .wdata_i (key_byte_i),
    .rdata_o (kb_rdata)
  );

  khte_ram #(.WIDTH(8), .DEPTH(ENTRIES * KEY_BYTES)) u_keys (
    .clk_i   (clk_i),
    .addr_i  (kr_addr),
    .we_i    (kr_we),
    .wdata_i (kb_rdata),
    .rdata_o (kr_rdata)
  );

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == khte_pkg::AddrBucketCount);
  assign prdata = (paddr == khte_pkg::AddrBucketCount) ? {21'd0, bc_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q <= 11'd1;
    end else if (cfg_wr) begin
      bc_q <= pwdata[10:0];
    end
  end

  // Effective bucket count.
  always_comb begin
    if (bc_q == 11'd0) begin
      eff = 11'd1;
    end else if (bc_q > khte_pkg::MaxBuckets) begin
      eff = khte_pkg::MaxBuckets;
    end else begin
      eff = bc_q;
    end
  end

  // One-at-a-time byte step and finalization.
  assign hb = acc_q + {24'd0, key_byte_i};
  assign hc = hb + (hb << 10);
  assign hn = hc ^ (hc >> 6);
  assign f1 = acc_q + (acc_q << 3);
  assign f2 = f1 ^ (f1 >> 11);
  assign f3 = f2 + (f2 << 15);

  // One remainder bit per cycle.
  always_comb begin
    div_t = {rem_q, h_q[5'd31 - divcnt_q]};
    if (div_t >= eff) begin
      div_t = div_t - eff;
    end
  end

  assign in_stall_o    = (state_q != khte_pkg::S_IDLE);
  assign in_take       = in_valid_i && !in_stall_o;
  assign entry_base    = KAW'(idx_q) * KAW'(KEY_BYTES);
  assign last_key_byte = ((LW'(j_q) + LW'(1)) == len_q);

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    acc_d        = acc_q;
    len_d        = len_q;
    ovl_d        = ovl_q;
    op_d         = op_q;
    val_d        = val_q;
    h_d          = h_q;
    idx_d        = idx_q;
    j_d          = j_q;
    free_d       = free_q;
    free_ok_d    = free_ok_q;
    hit_d        = hit_q;
    mword_d      = mword_q;
    st_d         = st_q;
    found_d      = found_q;
    rem_d        = rem_q;
    divcnt_d     = divcnt_q;
    out_valid_d  = out_valid_q;
    out_st_d     = out_st_q;
    out_found_d  = out_found_q;
    out_hash_d   = out_hash_q;
    out_bucket_d = out_bucket_q;

    meta_addr  = idx_q;
    meta_we    = 1'b0;
    meta_wdata = '0;
    kb_addr    = j_q;
    kb_we      = 1'b0;
    kr_addr    = entry_base + KAW'(j_q);
    kr_we      = 1'b0;

    // The output register empties when its transaction completes.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      khte_pkg::S_CLEAR: begin
        meta_we = 1'b1;
        if (idx_q == LastEntry) begin
          state_d = khte_pkg::S_IDLE;
        end else begin
          idx_d = idx_q + EW'(1);
        end
      end
      khte_pkg::S_IDLE: begin
        kb_addr = len_q[KBW-1:0];
        if (in_take) begin
          acc_d = hn;
          if (len_q < KeyMax) begin
            kb_we = 1'b1;
            len_d = len_q + LW'(1);
          end else begin
            ovl_d = 1'b1;
          end
          if (key_last_i) begin
            op_d    = operation_i;
            val_d   = value_i;
            state_d = khte_pkg::S_FIN;
          end
        end
      end
      khte_pkg::S_FIN: begin
        h_d       = f3;
        rem_d     = '0;
        divcnt_d  = '0;
        found_d   = '0;
        idx_d     = '0;
        free_ok_d = 1'b0;
        hit_d     = 1'b0;
        if (ovl_q) begin
          st_d    = khte_pkg::StTooLong;
          state_d = khte_pkg::S_MOD;
        end else begin
          state_d = khte_pkg::S_META_RD;
        end
      end
      khte_pkg::S_META_RD: begin
        state_d = khte_pkg::S_META_CHK;
      end
      khte_pkg::S_META_CHK: begin
        if (meta_rdata.valid && meta_rdata.hash == h_q && meta_rdata.len == len_q) begin
          mword_d = meta_rdata;
          j_d     = '0;
          state_d = khte_pkg::S_KEY_RD;
        end else begin
          if (!meta_rdata.valid && !free_ok_q) begin
            free_d    = idx_q;
            free_ok_d = 1'b1;
          end
          if (idx_q == LastEntry) begin
            state_d = khte_pkg::S_OP;
          end else begin
            idx_d   = idx_q + EW'(1);
            state_d = khte_pkg::S_META_RD;
          end
        end
      end
      khte_pkg::S_KEY_RD: begin
        state_d = khte_pkg::S_KEY_CHK;
      end
      khte_pkg::S_KEY_CHK: begin
        if (kr_rdata != kb_rdata) begin
          if (idx_q == LastEntry) begin
            state_d = khte_pkg::S_OP;
          end else begin
            idx_d   = idx_q + EW'(1);
            state_d = khte_pkg::S_META_RD;
          end
        end else if (last_key_byte) begin
          hit_d   = 1'b1;
          state_d = khte_pkg::S_OP;
        end else begin
          j_d     = j_q + KBW'(1);
          state_d = khte_pkg::S_KEY_RD;
        end
      end
      khte_pkg::S_OP: begin
        state_d = khte_pkg::S_MOD;
        if (op_q == khte_pkg::OpInsert) begin
          if (hit_q) begin
            meta_we          = 1'b1;
            meta_wdata       = mword_q;
            meta_wdata.value = val_q;
            st_d             = khte_pkg::StUpdated;
          end else if (free_ok_q) begin
            meta_addr        = free_q;
            meta_we          = 1'b1;
            meta_wdata.valid = 1'b1;
            meta_wdata.len   = len_q;
            meta_wdata.hash  = h_q;
            meta_wdata.value = val_q;
            st_d             = khte_pkg::StInserted;
            idx_d            = free_q;
            j_d              = '0;
            state_d          = khte_pkg::S_COPY_RD;
          end else begin
            st_d = khte_pkg::StFull;
          end
        end else if (op_q == khte_pkg::OpDelete) begin
          if (hit_q) begin
            meta_we          = 1'b1;
            meta_wdata       = mword_q;
            meta_wdata.valid = 1'b0;
            st_d             = khte_pkg::StDeleted;
          end else begin
            st_d = khte_pkg::StDelMiss;
          end
        end else begin
          if (hit_q) begin
            found_d = mword_q.value;
            st_d    = khte_pkg::StHit;
          end else begin
            st_d = khte_pkg::StMiss;
          end
        end
      end
      khte_pkg::S_COPY_RD: begin
        state_d = khte_pkg::S_COPY_WR;
      end
      khte_pkg::S_COPY_WR: begin
        kr_we = 1'b1;
        if (last_key_byte) begin
          state_d = khte_pkg::S_MOD;
        end else begin
          j_d     = j_q + KBW'(1);
          state_d = khte_pkg::S_COPY_RD;
        end
      end
      khte_pkg::S_MOD: begin
        rem_d    = div_t[9:0];
        divcnt_d = divcnt_q + 5'd1;
        if (divcnt_q == 5'd31) begin
          state_d = khte_pkg::S_DONE;
        end
      end
      khte_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_st_d     = st_q;
          out_found_d  = found_q;
          out_hash_d   = h_q;
          out_bucket_d = rem_q;
          acc_d        = '0;
          len_d        = '0;
          ovl_d        = 1'b0;
          state_d      = khte_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = khte_pkg::S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= khte_pkg::S_CLEAR;
      idx_q       <= '0;
      acc_q       <= '0;
      len_q       <= '0;
      ovl_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      acc_q       <= acc_d;
      len_q       <= len_d;
      ovl_q       <= ovl_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    val_q        <= val_d;
    h_q          <= h_d;
    j_q          <= j_d;
    free_q       <= free_d;
    free_ok_q    <= free_ok_d;
    hit_q        <= hit_d;
    mword_q      <= mword_d;
    st_q         <= st_d;
    found_q      <= found_d;
    rem_q        <= rem_d;
    divcnt_q     <= divcnt_d;
    out_st_q     <= out_st_d;
    out_found_q  <= out_found_d;
    out_hash_q   <= out_hash_d;
    out_bucket_q <= out_bucket_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_st_q;
  assign found_value_o = out_found_q;
  assign hash_value_o  = out_hash_q;
  assign bucket_o      = out_bucket_q;

endmodule

// ===== rtl/khte_ram.sv =====
module khte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port with registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

// Result expected for one completed key.
typedef struct {
  logic [2:0]  status;
  logic [31:0] found;
  logic [31:0] hash;
  logic [9:0]  bucket;
} lookup_result_t;

// Scoreboard: a model of the table that predicts each result on a final byte.
class table_scoreboard;
  logic [10:0] buckets;
  logic [7:0]  kbuf[32];
  int          klen;
  logic [31:0] acc;
  bit          overlong;
  bit          vld[64];
  logic [31:0] ehash[64];
  int          elen[64];
  logic [7:0]  ekey[64][32];
  logic [31:0] eval[64];
  lookup_result_t pending[$];
  int errors;

  function new();
    buckets = 11'd1;
    klen = 0; acc = 0; overlong = 0; errors = 0;
    foreach (vld[i]) vld[i] = 0;
  endfunction

  function int find_key(logic [31:0] h);
    bit same;
    for (int i = 0; i < 64; i++) begin
      if (vld[i] && ehash[i] == h && elen[i] == klen) begin
        same = 1;
        for (int j = 0; j < klen; j++) if (ekey[i][j] != kbuf[j]) same = 0;
        if (same) return i;
      end
    end
    return 64;
  endfunction

  // Note an accepted input transaction.
  function void note_byte(logic [1:0] op, logic [7:0] b, logic last, logic [31:0] v);
    logic [31:0] h;
    logic [10:0] eb;
    lookup_result_t r;
    int idx;
    h = acc + b;
    h += h << 10;
    h ^= h >> 6;
    acc = h;
    if (klen < 32) begin
      kbuf[klen] = b;
      klen++;
    end else overlong = 1;
    if (!last) return;
    h = acc;
    h += h << 3;
    h ^= h >> 11;
    h += h << 15;
    r.found = 0;
    if (overlong) r.status = khte_pkg::StTooLong;
    else begin
      idx = find_key(h);
      if (op == khte_pkg::OpInsert) begin
        if (idx < 64) begin
          eval[idx] = v; r.status = khte_pkg::StUpdated;
        end else begin
          idx = 0;
          while (idx < 64 && vld[idx]) idx++;
          if (idx < 64) begin
            vld[idx] = 1; ehash[idx] = h; elen[idx] = klen;
            for (int j = 0; j < 32; j++) ekey[idx][j] = kbuf[j];
            eval[idx] = v; r.status = khte_pkg::StInserted;
          end else r.status = khte_pkg::StFull;
        end
      end else if (op == khte_pkg::OpDelete) begin
        if (idx < 64) begin
          vld[idx] = 0; r.status = khte_pkg::StDeleted;
        end else r.status = khte_pkg::StDelMiss;
      end else begin
        if (idx < 64) begin
          r.found = eval[idx]; r.status = khte_pkg::StHit;
        end else r.status = khte_pkg::StMiss;
      end
    end
    eb = (buckets == 0) ? 11'd1 : (buckets > khte_pkg::MaxBuckets) ? khte_pkg::MaxBuckets
        : buckets;
    r.hash = h;
    r.bucket = 10'(h % eb);
    pending.push_back(r);
    klen = 0; acc = 0; overlong = 0;
    foreach (kbuf[i]) kbuf[i] = 0;
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // Check one accepted result against the oldest expectation.
  task check_result(logic [2:0] st, logic [31:0] fv, logic [31:0] hv, logic [9:0] bk);
    lookup_result_t e;
    if (pending.size() == 0) begin
      report("unexpected result", st, 0);
      return;
    end
    e = pending.pop_front();
    if (st !== e.status) report("status", st, e.status);
    if (fv !== e.found) report("found_value", fv, e.found);
    if (hv !== e.hash) report("hash_value", hv, e.hash);
    if (bk !== e.bucket) report("bucket", bk, e.bucket);
  endtask
endclass

module tb;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [1:0]  operation_i = '0;
  logic [7:0]  key_byte_i = '0;
  logic        key_last_i = 0;
  logic [31:0] value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [2:0]  status_o;
  logic [31:0] found_value_o, hash_value_o;
  logic [9:0]  bucket_o;

  table_scoreboard sb;
  bit hold_off = 0;
  bit stall_random = 1;
  // Small pool of keys so that inserts, hits and deletes meet.
  logic [7:0] key_pool[8][34];
  int         key_len[8];

  keyed_hash_table_engine_unit uut (.*);

  always #10 clk_i = ~clk_i;

  // Receiver: random stalls, plus a long forced hold-off when asked.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(status_o, found_value_o, hash_value_o, bucket_o);
    if (hold_off) out_stall_i <= 1;
    else if (!stall_random) out_stall_i <= 0;
    else out_stall_i <= ($urandom_range(9) < 3) ? 1'b1 : ($urandom_range(99) == 0);
  end

  function int gap_len();
    return ($urandom_range(19) == 0) ? $urandom_range(80, 20) : $urandom_range(2);
  endfunction

  // Send one byte transaction and wait for its acceptance.
  task send_byte(logic [1:0] op, logic [7:0] b, logic last, logic [31:0] v);
    in_valid_i <= 1; operation_i <= op; key_byte_i <= b;
    key_last_i <= last; value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(op, b, last, v);
  endtask

  task idle_gap(int n);
    if (n > 0) begin
      in_valid_i <= 0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Send a whole key; non-final bytes carry random op and value noise.
  task send_key(logic [1:0] op, int k, logic [31:0] v, bit gaps);
    for (int i = 0; i < key_len[k]; i++) begin
      send_byte(i == key_len[k] - 1 ? op : 2'($urandom), key_pool[k][i],
                i == key_len[k] - 1, i == key_len[k] - 1 ? v : $urandom);
      if (gaps) idle_gap(gap_len());
    end
  endtask

  task apb_write(logic [2:0] a, logic [31:0] d);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= d;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (a == khte_pkg::AddrBucketCount) sb.buckets = d[10:0];
  endtask

  // Wait until every expected result has come, then let the block settle.
  task drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function void new_key(int k, int len);
    key_len[k] = len;
    for (int i = 0; i < len; i++) key_pool[k][i] = 8'($urandom);
  endfunction

  initial begin
    int bc[6] = '{0, 1, 1024, 2047, 7, 1023};
    int k;
    logic [1:0] op;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    apb_write(khte_pkg::AddrBucketCount, 32'd1);
    // Directed: extreme bytes, every operation, zero value, overlong key.
    key_len[0] = 1; key_pool[0][0] = 8'h00;
    key_len[1] = 1; key_pool[1][0] = 8'hff;
    key_len[2] = 32; for (int i = 0; i < 32; i++) key_pool[2][i] = 8'(8'hff - i);
    key_len[3] = 33; for (int i = 0; i < 33; i++) key_pool[3][i] = 8'ha5;
    send_key(khte_pkg::OpInsert, 0, 32'h0, 0);
    send_key(khte_pkg::OpSearch, 0, 32'h0, 0);
    send_key(khte_pkg::OpInsert, 1, 32'hffff_ffff, 0);
    send_key(khte_pkg::OpInsert, 1, 32'h1234_5678, 0);
    send_key(khte_pkg::OpSpare, 1, 32'h0, 0);
    send_key(khte_pkg::OpInsert, 2, 32'hdead_beef, 0);
    send_key(khte_pkg::OpSearch, 2, 32'h0, 0);
    send_key(khte_pkg::OpInsert, 3, 32'h1, 0);
    send_key(khte_pkg::OpDelete, 0, 32'h0, 0);
    send_key(khte_pkg::OpDelete, 0, 32'h0, 0);
    send_key(khte_pkg::OpSearch, 0, 32'h0, 0);
    drain();
    apb_write(3'd4, 32'd5);
    // Fill the table to see full, then empty part of it.
    for (int i = 0; i < 66; i++) begin
      key_len[4] = 2; key_pool[4][0] = i[7:0]; key_pool[4][1] = 8'h5a;
      send_key(khte_pkg::OpInsert, 4, i, 0);
    end
    for (int i = 0; i < 40; i++) begin
      key_len[4] = 2; key_pool[4][0] = i[7:0]; key_pool[4][1] = 8'h5a;
      send_key(khte_pkg::OpDelete, 4, 0, 0);
    end
    // Long receiver hold-off while the sender keeps offering.
    fork
      begin
        hold_off = 1;
        repeat (600) @(posedge clk_i);
        hold_off = 0;
      end
      for (int i = 0; i < 10; i++) send_key(khte_pkg::OpInsert, 1, i, 0);
    join
    drain();
    // Random phases over several bucket counts.
    for (int p = 0; p < 6; p++) begin
      apb_write(khte_pkg::AddrBucketCount, bc[p] | ($urandom & 32'hffff_f800));
      stall_random = (p != 2);
      for (int i = 0; i < 8; i++) new_key(i, $urandom_range(9) == 0 ? $urandom_range(34, 20)
                                                              : $urandom_range(4, 1));
      for (int n = 0; n < 45; n++) begin
        k = $urandom_range(7);
        op = 2'($urandom);
        if ($urandom_range(9) == 0) begin
          // Noise: a new short key of random bytes in slot 7.
          new_key(7, $urandom_range(3, 1));
        end
        send_key(op, k, $urandom, p != 2);
        if (n % 20 == 0 && $urandom_range(1)) new_key($urandom_range(7), $urandom_range(5, 1));
      end
      drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
